// ----- design/mbs_pkg.sv -----
// ----------------------------------------------------------------------------
// Mode background subtractor package
// Shared constants, payload types and store layouts.
// ----------------------------------------------------------------------------
package mbs_pkg;

  localparam int PIXELS     = 1024;
  localparam int COUNT_BITS = 16;
  localparam int BINS       = 256;
  localparam int CHANNELS   = 3;

  localparam int IDX_W = 10;
  localparam int COL_W = 8;

  localparam int MODE_AW    = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int HIST_AW    = MODE_AW + COL_W;
  localparam int HIST_DEPTH = PIXELS * BINS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [COL_W-1:0] THR_RESET = 8'd30;

  // Register index: the byte address bits above the word offset
  localparam logic [CFG_AW-3:0] REG_STILL_THRESHOLD = '0;

  typedef logic [CHANNELS-1:0][COL_W-1:0]      col_arr_t;
  typedef logic [CHANNELS-1:0][COUNT_BITS-1:0] cnt_arr_t;

  typedef struct packed {
    logic [IDX_W-1:0] pixel_index;
    logic [COL_W-1:0] in_red;
    logic [COL_W-1:0] in_green;
    logic [COL_W-1:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [COL_W-1:0] out_red;
    logic [COL_W-1:0] out_green;
    logic [COL_W-1:0] out_blue;
    logic [COL_W-1:0] bg_red;
    logic [COL_W-1:0] bg_green;
    logic [COL_W-1:0] bg_blue;
    logic             moving;
  } pix_out_t;

  typedef struct packed {
    logic [COL_W-1:0]      val;
    logic [COUNT_BITS-1:0] cnt;
  } mode_entry_t;

  typedef mode_entry_t [CHANNELS-1:0] mode_row_t;

  // Item leaving the histogram stage towards classification
  typedef struct packed {
    logic     in_range;
    col_arr_t col;
    col_arr_t bg;
  } hist_item_t;

endpackage

// ----- design/mbs_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/mbs_hist_stage.sv -----
// ----------------------------------------------------------------------------
// Histogram stage
// Reads bins and modes on request, increments the bin, tracks the mode and
// writes both back. Clears the stores after reset.
// ----------------------------------------------------------------------------
module mbs_hist_stage import mbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  pix_in_t    in_data,
  output logic       c_valid,
  input  logic       c_ready,
  output hist_item_t c_item
);

  logic                clearing_r;
  logic [HIST_AW-1:0]  clr_cnt_r;
  logic                clr_mode_en;

  logic                in_acc;
  logic                in_range_a;
  col_arr_t            col_a;

  logic                b_vld_r;
  logic [IDX_W-1:0]    b_pix_r;
  col_arr_t            b_col_r;
  logic                b_in_range_r;
  logic                b_ready;
  logic                b_adv;

  logic                c_vld_r;
  logic [IDX_W-1:0]    c_pix_r;
  col_arr_t            c_col_r;
  logic                c_in_range_r;
  cnt_arr_t            c_cnt_r;
  mode_row_t           c_mode_r;

  cnt_arr_t            hist_rd;
  mode_row_t           mode_rd;
  cnt_arr_t            cur_cnt;
  cnt_arr_t            new_cnt;
  mode_row_t           cur_mode;
  mode_row_t           new_mode;
  logic                mode_hit;
  logic                upd_we;

  assign in_ready   = !clearing_r && b_ready;
  assign in_acc     = in_valid && in_ready;
  assign in_range_a = 32'(in_data.pixel_index) < PIXELS;
  assign col_a[0]   = in_data.in_red;
  assign col_a[1]   = in_data.in_green;
  assign col_a[2]   = in_data.in_blue;

  assign b_ready = !b_vld_r || !c_vld_r || c_ready;
  assign b_adv   = b_vld_r && b_ready;
  assign upd_we  = b_adv && b_in_range_r;

  assign clr_mode_en = clearing_r && (32'(clr_cnt_r) < PIXELS);

  // Clearing pass over every bin
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      if (clr_cnt_r == HIST_AW'(HIST_DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end else begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  for (genvar k = 0; k < CHANNELS; k++) begin : g_hist
    mbs_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
      .clk   (clk),
      .we    (clearing_r || upd_we),
      .waddr (clearing_r ? clr_cnt_r : {MODE_AW'(b_pix_r), b_col_r[k]}),
      .wdata (clearing_r ? '0 : new_cnt[k]),
      .re    (in_acc),
      .raddr ({MODE_AW'(in_data.pixel_index), col_a[k]}),
      .rdata (hist_rd[k])
    );
  end

  mbs_ram #(
    .WIDTH ($bits(mode_row_t)),
    .DEPTH (PIXELS)
  ) u_mode_ram (
    .clk   (clk),
    .we    (clr_mode_en || upd_we),
    .waddr (clearing_r ? clr_cnt_r[MODE_AW-1:0] : MODE_AW'(b_pix_r)),
    .wdata (clearing_r ? '0 : new_mode),
    .re    (in_acc),
    .raddr (MODE_AW'(in_data.pixel_index)),
    .rdata (mode_rd)
  );

  // Forward from the item one stage ahead: it wrote at the edge this one read
  always_comb begin
    mode_hit = c_vld_r && c_in_range_r && b_in_range_r && (c_pix_r == b_pix_r);
    cur_mode = mode_hit ? c_mode_r : mode_rd;
    new_mode = cur_mode;
    for (int k = 0; k < CHANNELS; k++) begin
      cur_cnt[k] = (mode_hit && (c_col_r[k] == b_col_r[k])) ? c_cnt_r[k] : hist_rd[k];
      new_cnt[k] = (cur_cnt[k] == COUNT_MAX) ? COUNT_MAX : cur_cnt[k] + 1'b1;
      if ((new_cnt[k] > cur_mode[k].cnt) ||
          ((new_cnt[k] == cur_mode[k].cnt) && (b_col_r[k] < cur_mode[k].val))) begin
        new_mode[k].cnt = new_cnt[k];
        new_mode[k].val = b_col_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      if (b_ready) begin
        b_vld_r <= in_acc;
      end
      if (!c_vld_r || c_ready) begin
        c_vld_r <= b_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_pix_r      <= in_data.pixel_index;
      b_col_r      <= col_a;
      b_in_range_r <= in_range_a;
    end
    if (b_adv) begin
      c_pix_r      <= b_pix_r;
      c_col_r      <= b_col_r;
      c_in_range_r <= b_in_range_r;
      c_cnt_r      <= new_cnt;
      c_mode_r     <= new_mode;
    end
  end

  assign c_valid = c_vld_r;

  always_comb begin
    c_item.in_range = c_in_range_r;
    c_item.col      = c_col_r;
    for (int k = 0; k < CHANNELS; k++) begin
      c_item.bg[k] = c_mode_r[k].val;
    end
  end

endmodule

// ----- design/mbs_classify.sv -----
// ----------------------------------------------------------------------------
// Still/moving classification
// Tests each channel against the still band and registers the result.
// ----------------------------------------------------------------------------
module mbs_classify import mbs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [COL_W-1:0] still_threshold,
  input  logic             c_valid,
  output logic             c_ready,
  input  hist_item_t       c_item,
  output logic             out_valid,
  input  logic             out_ready,
  output pix_out_t         out_data
);

  logic               out_vld_r;
  pix_out_t           out_data_r;
  pix_out_t           out_nxt;
  col_arr_t           bg;
  col_arr_t           sel;
  logic [COL_W-1:0]   diff;
  logic               still;

  assign c_ready = !out_vld_r || out_ready;

  // Still when |x - mode| < threshold on every channel
  always_comb begin
    still = c_item.in_range;
    for (int k = 0; k < CHANNELS; k++) begin
      bg[k] = c_item.in_range ? c_item.bg[k] : '0;
      diff  = (c_item.col[k] >= bg[k]) ? (c_item.col[k] - bg[k]) : (bg[k] - c_item.col[k]);
      if (!(diff < still_threshold)) begin
        still = 1'b0;
      end
    end
    for (int k = 0; k < CHANNELS; k++) begin
      sel[k] = still ? bg[k] : c_item.col[k];
    end
    out_nxt.out_red   = sel[0];
    out_nxt.out_green = sel[1];
    out_nxt.out_blue  = sel[2];
    out_nxt.bg_red    = bg[0];
    out_nxt.bg_green  = bg[1];
    out_nxt.bg_blue   = bg[2];
    out_nxt.moving    = !still;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (c_ready) begin
      out_vld_r <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_valid && c_ready) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/mode_background_subtractor.sv -----
// ----------------------------------------------------------------------------
// Mode background subtractor
// Per-pixel, per-channel value histograms; mode as background, still test.
// ----------------------------------------------------------------------------
// Pipeline: a request is registered in the read stage, then the update stage, then the result register.
// Throughput: one pixel per cycle while the result is not stalled; a bin read-modify-write each cycle per
//   channel, with forwarding between consecutive pixels at the same position.
// Reset: the histogram and mode stores are swept to zero, one bin per cycle,
//   over all PIXELS*256 bins (262144); in_ready stays low meanwhile.
// Threshold resets to 30; configuration writes are taken at any time.
module mode_background_subtractor import mbs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pix_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pix_out_t          out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [COL_W-1:0] thr_r;
  logic             reg_sel;
  logic             c_valid;
  logic             c_ready;
  hist_item_t       c_item;

  assign reg_sel    = cfg_paddr[CFG_AW-1:2] == REG_STILL_THRESHOLD;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_sel ? CFG_DW'(thr_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      thr_r <= cfg_pwdata[COL_W-1:0];
    end
  end

  mbs_hist_stage u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .c_valid  (c_valid),
    .c_ready  (c_ready),
    .c_item   (c_item)
  );

  mbs_classify u_classify (
    .clk             (clk),
    .rst_n           (rst_n),
    .still_threshold (thr_r),
    .c_valid         (c_valid),
    .c_ready         (c_ready),
    .c_item          (c_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data)
  );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mode background subtractor testbench
// Drives pixels at random rates against a random result stall, predicts each
// result from a local histogram and mode store, and checks results in order.
// Covers the still band edges, mode ties, threshold extremes and back-to-back
// pixels at one position.
// ----------------------------------------------------------------------------
module testbench;
  import mbs_pkg::*;

  localparam logic [CFG_AW-1:0] REG_STILL_THR = {REG_STILL_THRESHOLD, 2'b00};
  localparam int                POOL         = 16;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  pix_in_t           in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b1;
  pix_out_t          out_data;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  mode_background_subtractor u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #10 clk = ~clk;

  // Local copy of the histogram and mode stores
  bit [COUNT_BITS-1:0] bin_count [PIXELS*CHANNELS*BINS];
  bit [COL_W-1:0]      mode_val  [PIXELS*CHANNELS];
  bit [COUNT_BITS-1:0] mode_cnt  [PIXELS*CHANNELS];
  logic [COL_W-1:0]    still_thr = THR_RESET;

  pix_out_t pending_pixels[$];
  pix_out_t head_pixel;
  int       error_count = 0;
  bit       sender_idle = 1'b1;
  bit       back_pressure = 1'b1;
  int       stall_left = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(16, 40);
  endfunction

  function automatic int next_gap();
    if (!sender_idle || $urandom_range(0, 99) < 55) return 0;
    return pick_gap();
  endfunction

  function automatic pix_in_t mk(input logic [IDX_W-1:0] idx, input logic [COL_W-1:0] r,
                                 input logic [COL_W-1:0] g, input logic [COL_W-1:0] b);
    pix_in_t px;
    px.pixel_index = idx;
    px.in_red      = r;
    px.in_green    = g;
    px.in_blue     = b;
    return px;
  endfunction

  // Add the pixel to its bins, then derive background and still decision
  function automatic pix_out_t update_background(input pix_in_t px);
    pix_out_t res;
    logic [COL_W-1:0] col[CHANNELS];
    logic [COL_W-1:0] bg[CHANNELS];
    bit still;
    int slot, bin, v, m;
    col[0] = px.in_red;
    col[1] = px.in_green;
    col[2] = px.in_blue;
    still = 1'b1;
    if (int'(px.pixel_index) >= PIXELS) begin
      for (int k = 0; k < CHANNELS; k++) bg[k] = '0;
      still = 1'b0;
    end else begin
      for (int k = 0; k < CHANNELS; k++) begin
        slot = int'(px.pixel_index) * CHANNELS + k;
        bin  = slot * BINS + int'(col[k]);
        if (bin_count[bin] != COUNT_MAX) bin_count[bin] = bin_count[bin] + 1'b1;
        if (bin_count[bin] > mode_cnt[slot] ||
            (bin_count[bin] == mode_cnt[slot] && col[k] < mode_val[slot])) begin
          mode_cnt[slot] = bin_count[bin];
          mode_val[slot] = col[k];
        end
        bg[k] = mode_val[slot];
        v = int'(col[k]);
        m = int'(bg[k]);
        if (!(v > m - int'(still_thr) && v < m + int'(still_thr))) still = 1'b0;
      end
    end
    res.out_red   = still ? bg[0] : col[0];
    res.out_green = still ? bg[1] : col[1];
    res.out_blue  = still ? bg[2] : col[2];
    res.bg_red    = bg[0];
    res.bg_green  = bg[1];
    res.bg_blue   = bg[2];
    res.moving    = !still;
    return res;
  endfunction

  // Entered and left at a falling edge; valid stays high into the next request
  task automatic send_pixel(input pix_in_t px, input int gap);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = px;
    do @(posedge clk); while (!in_ready);
    pending_pixels = {pending_pixels, update_background(px)};
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
  endtask

  task automatic apb_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = addr;
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == REG_STILL_THR) still_thr = data[COL_W-1:0];
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic check_threshold_reg(input logic [COL_W-1:0] want);
    logic [CFG_DW-1:0] got;
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = REG_STILL_THR;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    if (got != CFG_DW'(want))
      report_mismatch($sformatf("still_threshold read %h, want %h", got, want));
  endtask

  task automatic set_threshold(input logic [COL_W-1:0] thr);
    wait_drain();
    repeat (6) @(negedge clk);
    apb_write(REG_STILL_THR, CFG_DW'(thr));
    check_threshold_reg(thr);
  endtask

  task automatic compare_field(input string name, input logic [COL_W-1:0] want,
                               input logic [COL_W-1:0] got);
    if (got !== want) report_mismatch($sformatf("%s got %h, want %h", name, got, want));
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing pending", out_data));
      end else begin
        head_pixel = pending_pixels.pop_front();
        compare_field("out_red",   head_pixel.out_red,   out_data.out_red);
        compare_field("out_green", head_pixel.out_green, out_data.out_green);
        compare_field("out_blue",  head_pixel.out_blue,  out_data.out_blue);
        compare_field("bg_red",    head_pixel.bg_red,    out_data.bg_red);
        compare_field("bg_green",  head_pixel.bg_green,  out_data.bg_green);
        compare_field("bg_blue",   head_pixel.bg_blue,   out_data.bg_blue);
        compare_field("moving",    COL_W'(head_pixel.moving), COL_W'(out_data.moving));
      end
    end
  end

  // Result-side stall
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (back_pressure && $urandom_range(0, 99) < 25) begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic test_register_reset();
    check_threshold_reg(THR_RESET);
  endtask

  task automatic test_directed_pixels();
    // Same position back to back, then the far corner
    send_pixel(mk(10'd0, 8'd0, 8'd0, 8'd0), 0);
    send_pixel(mk(10'd0, 8'd0, 8'd0, 8'd0), 0);
    send_pixel(mk(10'd1023, 8'd255, 8'd255, 8'd255), next_gap());
    // Tie in count: the smaller value takes the mode
    send_pixel(mk(10'd5, 8'd100, 8'd0, 8'd0), next_gap());
    send_pixel(mk(10'd5, 8'd50, 8'd0, 8'd0), next_gap());
    send_pixel(mk(10'd5, 8'd100, 8'd0, 8'd0), 0);
    // Band edges around a mode of 100
    send_pixel(mk(10'd10, 8'd100, 8'd100, 8'd100), next_gap());
    send_pixel(mk(10'd10, 8'd100, 8'd100, 8'd100), next_gap());
    send_pixel(mk(10'd10, 8'd130, 8'd100, 8'd100), next_gap());
    send_pixel(mk(10'd10, 8'd70, 8'd100, 8'd100), next_gap());
    send_pixel(mk(10'd10, 8'd71, 8'd129, 8'd100), next_gap());
    send_pixel(mk(10'h2AA, 8'hAA, 8'h55, 8'hAA), next_gap());
    send_pixel(mk(10'h155, 8'h55, 8'hAA, 8'h55), 0);
    // Zero threshold: never still
    set_threshold(8'd0);
    send_pixel(mk(10'd10, 8'd100, 8'd100, 8'd100), next_gap());
    // Widest band: only the far edge is moving
    set_threshold(8'd255);
    send_pixel(mk(10'd20, 8'd255, 8'd255, 8'd255), next_gap());
    send_pixel(mk(10'd20, 8'd255, 8'd255, 8'd255), next_gap());
    send_pixel(mk(10'd20, 8'd0, 8'd255, 8'd255), next_gap());
    send_pixel(mk(10'd20, 8'd1, 8'd255, 8'd255), next_gap());
  endtask

  function automatic logic [COL_W-1:0] near(input logic [COL_W-1:0] base);
    int v;
    v = int'(base) + $urandom_range(0, 12) - 6;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return COL_W'(v);
  endfunction

  task automatic test_random_traffic();
    logic [IDX_W-1:0] pool_idx[POOL];
    logic [COL_W-1:0] base[POOL][CHANNELS];
    logic [COL_W-1:0] thr_list[5];
    logic [IDX_W-1:0] last_idx;
    pix_in_t px;
    int r, p;
    thr_list = '{8'd30, 8'd0, 8'd255, 8'd1, COL_W'($urandom_range(2, 254))};
    for (int i = 0; i < POOL; i++) begin
      pool_idx[i] = IDX_W'($urandom);
      for (int k = 0; k < CHANNELS; k++) base[i][k] = COL_W'($urandom);
    end
    pool_idx[0] = '0;
    pool_idx[1] = IDX_W'(PIXELS - 1);
    last_idx = pool_idx[0];
    for (int ph = 0; ph < 5; ph++) begin
      set_threshold(thr_list[ph]);
      // One phase runs flat out on both sides
      sender_idle   = (ph != 2);
      back_pressure = (ph != 2);
      for (int n = 0; n < 370; n++) begin
        if (ph == 1 && n == 185) wait_drain();
        r = $urandom_range(0, 99);
        if (r < 70) begin
          p = $urandom_range(0, POOL - 1);
          // Drift a background now and then so modes move
          if ($urandom_range(0, 99) < 3) base[p][$urandom_range(0, 2)] = COL_W'($urandom);
          px = mk(pool_idx[p], near(base[p][0]), near(base[p][1]), near(base[p][2]));
        end else if (r < 82) begin
          px = mk(last_idx, COL_W'($urandom), COL_W'($urandom), COL_W'($urandom));
        end else begin
          px = mk(IDX_W'($urandom), COL_W'($urandom), COL_W'($urandom), COL_W'($urandom));
        end
        last_idx = px.pixel_index;
        send_pixel(px, next_gap());
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    test_register_reset();
    test_directed_pixels();
    test_random_traffic();
    wait_drain();
    repeat (12) @(negedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/mbs_pkg.sv
design/mbs_ram.sv
design/mbs_hist_stage.sv
design/mbs_classify.sv
design/mode_background_subtractor.sv
bench/testbench.sv
